FILE: src/jst_pkg.sv
// ----------------------------------------------------------------------------
// jst_pkg
// Shared types and constants for the JSON stream tokenizer.
// ----------------------------------------------------------------------------
package jst_pkg;

   typedef enum logic [4:0] {
      M_VALUE, M_ARR_FIRST, M_OBJ_FIRST, M_OBJ_KEY, M_COLON, M_AFTER, M_TRAILING,
      M_STRING, M_ESC, M_HEX, M_TRUE, M_FALSE, M_NULL,
      M_N_SIGN, M_N_ZERO, M_N_INT, M_N_DOT, M_N_FRAC, M_N_EXP, M_N_EXPSIGN,
      M_N_EXPDIG
   } mode_type;

   typedef enum logic [3:0] {
      EV_OBJOPEN, EV_OBJCLOSE, EV_ARROPEN, EV_ARRCLOSE, EV_KEYBYTE, EV_KEYEND,
      EV_STRBYTE, EV_STREND, EV_NUMBYTE, EV_NUMEND, EV_TRUE, EV_FALSE, EV_NULL,
      EV_NOTHING, EV_ERROR, EV_DONE
   } event_type;

   typedef enum logic [2:0] {
      CAUSE_NONE, CAUSE_BYTE, CAUSE_END, CAUSE_DEEP, CAUSE_ESCAPE
   } cause_type;

   localparam int          SLOTS      = 3;
   localparam int          QUEUE_SIZE = 4;
   localparam int          QPTR_W     = 2;
   localparam logic [7:0]  UTF_LEAD2  = 8'hC0;
   localparam logic [7:0]  UTF_LEAD3  = 8'hE0;
   localparam logic [7:0]  UTF_CONT   = 8'h80;
   localparam logic [7:0]  UTF_MASK   = 8'h3F;
   localparam logic [15:0] UTF_ONE    = 16'h0080;
   localparam logic [15:0] UTF_TWO    = 16'h0800;

   typedef struct packed {
      logic [1:0]                 last;
      event_type [SLOTS-1:0]      ev;
      logic [SLOTS-1:0][7:0]      data;
      logic [SLOTS-1:0][5:0]      depth;
      cause_type [SLOTS-1:0]      cause;
   } bundle_type;

   function automatic logic [7:0] lit_char(input mode_type m, input logic [2:0] idx);
      logic [7:0] r;
      r = 8'h00;
      case (m)
         M_TRUE: begin
            case (idx)
               3'd1: r = 8'h72;
               3'd2: r = 8'h75;
               3'd3: r = 8'h65;
               default: r = 8'h00;
            endcase
         end
         M_FALSE: begin
            case (idx)
               3'd1: r = 8'h61;
               3'd2: r = 8'h6C;
               3'd3: r = 8'h73;
               3'd4: r = 8'h65;
               default: r = 8'h00;
            endcase
         end
         default: begin
            case (idx)
               3'd1: r = 8'h75;
               3'd2: r = 8'h6C;
               3'd3: r = 8'h6C;
               default: r = 8'h00;
            endcase
         end
      endcase
      return r;
   endfunction

endpackage

FILE: src/json_stream_tokenizer.sv
// Each accepted byte pushes one result bundle into the queue; its results follow in order.
// Throughput: one byte per cycle unless req_stall (queue full); each byte gives one to
// three results, sent one per transfer by the sender draining a four-bundle queue.
// Reset: synchronous; clears grammar state, depth, sticky error, queue and sender.
// ----------------------------------------------------------------------------
// json_stream_tokenizer
// Byte-serial JSON validator and tokenizer, top level.
// ----------------------------------------------------------------------------
module json_stream_tokenizer #(
   parameter int MAX_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_event_res,
   output logic [7:0] rsp_data_byte,
   output logic [5:0] rsp_nesting_depth,
   output logic [2:0] rsp_error_cause,
   output logic       rsp_run_last
);
   import jst_pkg::*;

   bundle_type push_bundle;
   bundle_type head_bundle;
   logic       push, full, pop, head_valid;

   jst_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .q_full          (full),
      .q_push          (push),
      .q_bundle        (push_bundle)
   );

   jst_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .full        (full),
      .pop         (pop),
      .head_valid  (head_valid),
      .head_bundle (head_bundle)
   );

   jst_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_bundle       (head_bundle),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_res     (rsp_event_res),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_nesting_depth (rsp_nesting_depth),
      .rsp_error_cause   (rsp_error_cause),
      .rsp_run_last      (rsp_run_last)
   );

endmodule

FILE: src/jst_front.sv
// ----------------------------------------------------------------------------
// jst_front
// Grammar tracker: takes one byte per transfer and builds its result bundle.
// ----------------------------------------------------------------------------
module jst_front #(
   parameter int MAX_DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_text_byte,
   input  logic                req_end_of_text,
   input  logic                q_full,
   output logic                q_push,
   output jst_pkg::bundle_type q_bundle
);
   import jst_pkg::*;

   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   mode_type              mode_ff, mode_in;
   logic [DW-1:0]         depth_ff, depth_in;
   logic                  key_ff, key_in;
   logic [2:0]            lit_ff, lit_in;
   logic [15:0]           hex_ff, hex_in;
   logic [2:0]            hcnt_ff, hcnt_in;
   logic                  sticky_ff, sticky_in;
   cause_type             code_ff, code_in;
   logic [MAX_DEPTH-1:0]  stack_ff;
   logic                  stack_we;
   logic                  stack_kind;
   logic [DW-1:0]         depth_m1;
   logic [1:0]            tk;
   logic                  accept;
   bundle_type            res;

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;
   assign q_push    = accept;
   assign q_bundle  = res;
   assign depth_m1  = depth_ff - DW'(1);
   assign tk        = (depth_ff == '0) ? 2'd2 : {1'b0, stack_ff[depth_m1[IW-1:0]]};

   always_comb begin
      mode_type   m;
      logic [1:0] n;
      logic [7:0] c;
      logic       ws, dig, ee, term, do_start, do_close, close_kind, hv;
      logic [3:0] h;
      logic [15:0] code;
      logic [2:0] len;
      event_type  sev, lev;
      mode_type   vdm;
      m          = mode_ff;
      n          = 2'd0;
      c          = req_text_byte;
      depth_in   = depth_ff;
      key_in     = key_ff;
      lit_in     = lit_ff;
      hex_in     = hex_ff;
      hcnt_in    = hcnt_ff;
      sticky_in  = sticky_ff;
      code_in    = code_ff;
      stack_we   = 1'b0;
      stack_kind = 1'b0;
      do_start   = 1'b0;
      do_close   = 1'b0;
      close_kind = 1'b0;
      term       = 1'b0;
      code       = 16'h0000;
      len        = 3'd4;
      lev        = EV_TRUE;
      h          = 4'h0;
      hv         = 1'b0;
      res.last   = 2'd0;
      for (int i = 0; i < SLOTS; i++) begin
         res.ev[i]    = EV_NOTHING;
         res.data[i]  = 8'h00;
         res.depth[i] = 6'd0;
         res.cause[i] = CAUSE_NONE;
      end
      ws   = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
      dig  = (c >= 8'h30) && (c <= 8'h39);
      ee   = (c == 8'h65) || (c == 8'h45);
      sev  = key_ff ? EV_KEYBYTE : EV_STRBYTE;
      vdm  = (depth_ff == '0) ? M_TRAILING : M_AFTER;
      if (c >= 8'h30 && c <= 8'h39) begin
         h = c[3:0]; hv = 1'b1;
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         h = c[3:0] + 4'd9; hv = 1'b1;
      end

      if (sticky_ff) begin
         res.ev[n] = EV_ERROR; res.depth[n] = 6'(depth_in); res.cause[n] = code_ff;
         n = n + 2'd1;
      end else if (req_end_of_text) begin
         if (m == M_N_ZERO || m == M_N_INT || m == M_N_FRAC || m == M_N_EXPDIG) begin
            res.ev[n] = EV_NUMEND; res.depth[n] = 6'(depth_in); n = n + 2'd1;
            m = vdm;
         end
         if (m == M_TRAILING) begin
            res.ev[n] = EV_DONE; res.depth[n] = 6'(depth_in); n = n + 2'd1;
            m = M_VALUE; depth_in = '0; key_in = 1'b0; lit_in = 3'd0;
            hex_in = 16'h0000; hcnt_in = 3'd0; sticky_in = 1'b0; code_in = CAUSE_NONE;
         end else begin
            sticky_in = 1'b1; code_in = CAUSE_END;
            res.ev[n] = EV_ERROR; res.depth[n] = 6'(depth_in); res.cause[n] = CAUSE_END;
            n = n + 2'd1;
         end
      end else begin
         case (m)
            M_N_ZERO:   term = !((c == 8'h2E) || ee);
            M_N_INT:    term = !(dig || (c == 8'h2E) || ee);
            M_N_FRAC:   term = !(dig || ee);
            M_N_EXPDIG: term = !dig;
            default:    term = 1'b0;
         endcase
         if (term) begin
            res.ev[n] = EV_NUMEND; res.depth[n] = 6'(depth_in); n = n + 2'd1;
            m = vdm;
         end
         case (m)
            M_VALUE, M_ARR_FIRST: begin
               if (!ws) begin
                  if (m == M_ARR_FIRST && c == 8'h5D) begin
                     do_close = 1'b1; close_kind = 1'b1;
                  end else begin
                     do_start = 1'b1;
                  end
               end
            end
            M_OBJ_FIRST, M_OBJ_KEY: begin
               if (!ws) begin
                  if (c == 8'h22) begin
                     key_in = 1'b1; m = M_STRING;
                  end else if (c == 8'h7D && m == M_OBJ_FIRST) begin
                     do_close = 1'b1;
                  end else begin
                     sticky_in = 1'b1; code_in = CAUSE_BYTE;
                  end
               end
            end
            M_COLON: begin
               if (!ws) begin
                  if (c == 8'h3A) m = M_VALUE;
                  else begin
                     sticky_in = 1'b1; code_in = CAUSE_BYTE;
                  end
               end
            end
            M_AFTER: begin
               if (!ws) begin
                  if (c == 8'h2C) begin
                     if (tk == 2'd1) m = M_VALUE;
                     else if (tk == 2'd0) m = M_OBJ_KEY;
                     else begin
                        sticky_in = 1'b1; code_in = CAUSE_BYTE;
                     end
                  end else if (c == 8'h7D) begin
                     do_close = 1'b1;
                  end else if (c == 8'h5D) begin
                     do_close = 1'b1; close_kind = 1'b1;
                  end else begin
                     sticky_in = 1'b1; code_in = CAUSE_BYTE;
                  end
               end
            end
            M_TRAILING: begin
               if (!ws) begin
                  sticky_in = 1'b1; code_in = CAUSE_BYTE;
               end
            end
            M_STRING: begin
               if (c == 8'h22) begin
                  res.ev[n] = key_ff ? EV_KEYEND : EV_STREND;
                  res.depth[n] = 6'(depth_in); n = n + 2'd1;
                  m = key_ff ? M_COLON : vdm;
                  key_in = 1'b0;
               end else if (c == 8'h5C) begin
                  m = M_ESC;
               end else begin
                  res.ev[n] = sev; res.data[n] = c; res.depth[n] = 6'(depth_in);
                  n = n + 2'd1;
               end
            end
            M_ESC: begin
               m = M_STRING;
               res.ev[n] = sev; res.depth[n] = 6'(depth_in);
               case (c)
                  8'h22, 8'h5C, 8'h2F: begin res.data[n] = c;     n = n + 2'd1; end
                  8'h6E:               begin res.data[n] = 8'h0A; n = n + 2'd1; end
                  8'h74:               begin res.data[n] = 8'h09; n = n + 2'd1; end
                  8'h72:               begin res.data[n] = 8'h0D; n = n + 2'd1; end
                  8'h62:               begin res.data[n] = 8'h08; n = n + 2'd1; end
                  8'h66:               begin res.data[n] = 8'h0C; n = n + 2'd1; end
                  8'h75: begin
                     res.ev[n] = EV_NOTHING;
                     hex_in = 16'h0000; hcnt_in = 3'd0; m = M_HEX;
                  end
                  default: begin
                     res.ev[n] = EV_NOTHING;
                     sticky_in = 1'b1; code_in = CAUSE_ESCAPE;
                  end
               endcase
            end
            M_HEX: begin
               if (!hv) begin
                  sticky_in = 1'b1; code_in = CAUSE_ESCAPE;
               end else begin
                  hex_in  = {hex_ff[11:0], h};
                  hcnt_in = hcnt_ff + 3'd1;
                  if (hcnt_in == 3'd4) begin
                     code    = hex_in;
                     hcnt_in = 3'd0;
                     m       = M_STRING;
                     if (code < UTF_ONE) begin
                        res.ev[0] = sev; res.data[0] = code[7:0];
                        res.depth[0] = 6'(depth_in); n = 2'd1;
                     end else if (code < UTF_TWO) begin
                        res.ev[0] = sev; res.data[0] = UTF_LEAD2 | {3'b000, code[10:6]};
                        res.ev[1] = sev; res.data[1] = UTF_CONT | (code[7:0] & UTF_MASK);
                        res.depth[0] = 6'(depth_in); res.depth[1] = 6'(depth_in);
                        n = 2'd2;
                     end else begin
                        res.ev[0] = sev; res.data[0] = UTF_LEAD3 | {4'h0, code[15:12]};
                        res.ev[1] = sev;
                        res.data[1] = UTF_CONT | ({2'b00, code[11:6]} & UTF_MASK);
                        res.ev[2] = sev; res.data[2] = UTF_CONT | (code[7:0] & UTF_MASK);
                        res.depth[0] = 6'(depth_in); res.depth[1] = 6'(depth_in);
                        res.depth[2] = 6'(depth_in);
                        n = 2'd3;
                     end
                  end
               end
            end
            M_TRUE, M_FALSE, M_NULL: begin
               len = (m == M_FALSE) ? 3'd5 : 3'd4;
               lev = (m == M_TRUE) ? EV_TRUE : ((m == M_FALSE) ? EV_FALSE : EV_NULL);
               if (lit_ff >= len || c != lit_char(m, lit_ff)) begin
                  sticky_in = 1'b1; code_in = CAUSE_BYTE;
               end else begin
                  lit_in = lit_ff + 3'd1;
                  if (lit_in == len) begin
                     lit_in = 3'd0;
                     res.ev[n] = lev; res.depth[n] = 6'(depth_in); n = n + 2'd1;
                     m = vdm;
                  end
               end
            end
            M_N_SIGN, M_N_ZERO, M_N_INT, M_N_DOT, M_N_FRAC, M_N_EXP, M_N_EXPSIGN,
            M_N_EXPDIG: begin
               res.ev[n] = EV_NUMBYTE; res.data[n] = c; res.depth[n] = 6'(depth_in);
               case (m)
                  M_N_SIGN:    m = (c == 8'h30) ? M_N_ZERO : (dig ? M_N_INT : m);
                  M_N_ZERO,
                  M_N_INT:     m = dig ? M_N_INT : ((c == 8'h2E) ? M_N_DOT : M_N_EXP);
                  M_N_DOT:     m = dig ? M_N_FRAC : m;
                  M_N_FRAC:    m = dig ? M_N_FRAC : M_N_EXP;
                  M_N_EXP:     m = dig ? M_N_EXPDIG :
                                   ((c == 8'h2B || c == 8'h2D) ? M_N_EXPSIGN : m);
                  M_N_EXPSIGN: m = dig ? M_N_EXPDIG : m;
                  default:     m = M_N_EXPDIG;
               endcase
               if ((mode_ff == M_N_SIGN && !dig) || (mode_ff == M_N_DOT && !dig) ||
                   (mode_ff == M_N_EXPSIGN && !dig) ||
                   (mode_ff == M_N_EXP && !dig && c != 8'h2B && c != 8'h2D)) begin
                  res.ev[n] = EV_NOTHING; res.data[n] = 8'h00;
                  sticky_in = 1'b1; code_in = CAUSE_BYTE;
               end else begin
                  n = n + 2'd1;
               end
            end
            default: begin
               sticky_in = 1'b1; code_in = CAUSE_BYTE;
            end
         endcase

         if (do_close) begin
            if (tk != {1'b0, close_kind}) begin
               sticky_in = 1'b1; code_in = CAUSE_BYTE;
            end else begin
               depth_in = depth_ff - DW'(1);
               res.ev[n] = close_kind ? EV_ARRCLOSE : EV_OBJCLOSE;
               res.depth[n] = 6'(depth_in); n = n + 2'd1;
               m = (depth_in == '0) ? M_TRAILING : M_AFTER;
            end
         end
         if (do_start) begin
            case (c)
               8'h7B, 8'h5B: begin
                  if (depth_ff >= DW'(MAX_DEPTH)) begin
                     sticky_in = 1'b1; code_in = CAUSE_DEEP;
                  end else begin
                     stack_we   = 1'b1;
                     stack_kind = (c == 8'h5B);
                     depth_in   = depth_ff + DW'(1);
                     res.ev[n]  = stack_kind ? EV_ARROPEN : EV_OBJOPEN;
                     res.depth[n] = 6'(depth_in); n = n + 2'd1;
                     m = stack_kind ? M_ARR_FIRST : M_OBJ_FIRST;
                  end
               end
               8'h22: begin key_in = 1'b0; m = M_STRING; end
               8'h74: begin lit_in = 3'd1; m = M_TRUE; end
               8'h66: begin lit_in = 3'd1; m = M_FALSE; end
               8'h6E: begin lit_in = 3'd1; m = M_NULL; end
               default: begin
                  if (c == 8'h2D || dig) begin
                     res.ev[n] = EV_NUMBYTE; res.data[n] = c;
                     res.depth[n] = 6'(depth_in); n = n + 2'd1;
                     m = (c == 8'h2D) ? M_N_SIGN : ((c == 8'h30) ? M_N_ZERO : M_N_INT);
                  end else begin
                     sticky_in = 1'b1; code_in = CAUSE_BYTE;
                  end
               end
            endcase
         end
         if (sticky_in) begin
            res.ev[n] = EV_ERROR; res.data[n] = 8'h00;
            res.depth[n] = 6'(depth_in); res.cause[n] = code_in;
            n = n + 2'd1;
         end
      end

      if (n == 2'd0) begin
         res.ev[0] = EV_NOTHING; res.depth[0] = 6'(depth_in);
         n = 2'd1;
      end
      res.last = n - 2'd1;
      mode_in  = m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_VALUE;
         depth_ff  <= '0;
         key_ff    <= 1'b0;
         lit_ff    <= 3'd0;
         hex_ff    <= 16'h0000;
         hcnt_ff   <= 3'd0;
         sticky_ff <= 1'b0;
         code_ff   <= CAUSE_NONE;
      end else if (accept) begin
         mode_ff   <= mode_in;
         depth_ff  <= depth_in;
         key_ff    <= key_in;
         lit_ff    <= lit_in;
         hex_ff    <= hex_in;
         hcnt_ff   <= hcnt_in;
         sticky_ff <= sticky_in;
         code_ff   <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && stack_we) begin
         stack_ff[depth_ff[IW-1:0]] <= stack_kind;
      end
   end

endmodule

FILE: src/jst_fifo.sv
// ----------------------------------------------------------------------------
// jst_fifo
// Short queue of result bundles between the grammar tracker and the sender.
// ----------------------------------------------------------------------------
module jst_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jst_pkg::bundle_type push_bundle,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output jst_pkg::bundle_type head_bundle
);
   import jst_pkg::*;

   bundle_type          store_ff [QUEUE_SIZE];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;

   assign full        = (cnt_ff == (QPTR_W + 1)'(QUEUE_SIZE));
   assign head_valid  = (cnt_ff != '0);
   assign head_bundle = store_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ff] <= push_bundle;
      end
   end

endmodule

FILE: src/jst_back.sv
// ----------------------------------------------------------------------------
// jst_back
// Result sender: walks the slots of the head bundle, one transfer each.
// ----------------------------------------------------------------------------
module jst_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  jst_pkg::bundle_type head_bundle,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_event_res,
   output logic [7:0]          rsp_data_byte,
   output logic [5:0]          rsp_nesting_depth,
   output logic [2:0]          rsp_error_cause,
   output logic                rsp_run_last
);
   import jst_pkg::*;

   logic [1:0] slot_ff, slot_in;
   logic       take;
   logic       is_last;

   assign rsp_valid         = head_valid;
   assign take              = head_valid & ~rsp_stall;
   assign is_last           = (slot_ff == head_bundle.last);
   assign pop               = take & is_last;
   assign rsp_event_res     = head_bundle.ev[slot_ff];
   assign rsp_data_byte     = head_bundle.data[slot_ff];
   assign rsp_nesting_depth = head_bundle.depth[slot_ff];
   assign rsp_error_cause   = head_bundle.cause[slot_ff];
   assign rsp_run_last      = is_last;

   always_comb begin
      slot_in = slot_ff;
      if (take) begin
         slot_in = is_last ? 2'd0 : slot_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= 2'd0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule
